/* design/pwi_pkg.sv */
// Shared widths, sizing constants and register indexes for the windowed-integral PID core.
`timescale 1ns / 1ps

package pwi_pkg;

  // Window of stored errors; a power of two so the average is a shift
  localparam int unsigned Window   = 16;
  localparam int unsigned WinShift = $clog2(Window);
  localparam int unsigned PtrW     = (WinShift > 0) ? WinShift : 1;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ErrW    = SampleW + 1;
  localparam int unsigned DerivW  = ErrW + 1;
  localparam int unsigned SumW    = ErrW + WinShift;
  localparam int unsigned DriveW  = 32;

  // Product and accumulator widths
  localparam int unsigned ProdEW = GainW + ErrW;
  localparam int unsigned ProdDW = GainW + DerivW;
  localparam int unsigned AccW   = ProdDW + 2;
  localparam int unsigned FracW  = 8;

  // Stream payload widths, padded to whole bytes
  localparam int unsigned InDataW  = 2 * SampleW;
  localparam int unsigned OutRawW  = DriveW + ErrW;
  localparam int unsigned OutDataW = ((OutRawW + 7) / 8) * 8;
  localparam int unsigned OutPadW  = OutDataW - OutRawW;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    GAIN_PROP  = 2'd0,
    GAIN_INTEG = 2'd1,
    GAIN_DERIV = 2'd2
  } cfg_idx_e;

endpackage

/* design/pid_windowed_integral_core.sv */
// PID controller with a moving-window average integral, streaming in and out.
// An accepted request is registered in turn in the error stage, the product stage and
// the sum and saturate stage before a valid result. Throughput: one request per cycle
// while the result stream is not stalled; each stage moves on when the stage after it is
// empty or emptying, set by the result register. Reset clears the error ring, window sum,
// ring pointer, previous error, gains and all stage valid flags.
`timescale 1ns / 1ps

module pid_windowed_integral_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [pwi_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pwi_pkg::GainW-1:0]         cfg_data_i,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [pwi_pkg::InDataW-1:0]       s_axis_tdata,  // target_value, measured_value
  // Result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [pwi_pkg::OutDataW-1:0]      m_axis_tdata   // drive_value, error_now, zero pad
);
  import pwi_pkg::*;

  // Gains
  logic signed [GainW-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;

  // Controller state
  logic signed [ErrW-1:0] ring_q [Window];
  logic [PtrW-1:0]        ptr_q;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic signed [ErrW-1:0] last_err_q;

  // Stage valids and handshake
  logic v_a_q, v_b_q, v_c_q;
  logic rdy_a, rdy_b, rdy_c;
  logic in_acc;

  // Stage A payload
  logic signed [SampleW-1:0] target, measured;
  logic signed [ErrW-1:0]    err_d, err_a_q, avg_d, avg_a_q;
  logic signed [DerivW-1:0]  der_d, der_a_q;

  // Stage B payload
  logic signed [ProdEW-1:0] prod_p_d, prod_p_q, prod_i_d, prod_i_q;
  logic signed [ProdDW-1:0] prod_d_d, prod_d_q;
  logic signed [ErrW-1:0]   err_b_q;

  // Stage C payload
  logic signed [AccW-1:0]   acc, acc_sh;
  logic signed [DriveW-1:0] drive_d, drive_c_q;
  logic signed [ErrW-1:0]   err_c_q;

  // Handshake: each stage takes new data when it is empty or its content moves on
  assign rdy_c         = !v_c_q || m_axis_tready;
  assign rdy_b         = !v_b_q || rdy_c;
  assign rdy_a         = !v_a_q || rdy_b;
  assign s_axis_tready = rdy_a;
  assign in_acc        = s_axis_tvalid && rdy_a;

  // Write gains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        GAIN_PROP:  gain_prop_q  <= cfg_data_i;
        GAIN_INTEG: gain_integ_q <= cfg_data_i;
        GAIN_DERIV: gain_deriv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Error, window sum, average and derivative for the incoming request
  always_comb begin
    target   = s_axis_tdata[SampleW-1:0];
    measured = s_axis_tdata[2*SampleW-1:SampleW];
    err_d    = ErrW'(target) - ErrW'(measured);
    sum_d    = sum_q - SumW'(ring_q[ptr_q]) + SumW'(err_d);
    avg_d    = ErrW'(sum_d >>> WinShift);
    der_d    = DerivW'(err_d) - DerivW'(last_err_q);
  end

  // Update the ring and running sum on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) ring_q[i] <= '0;
      ptr_q      <= '0;
      sum_q      <= '0;
      last_err_q <= '0;
    end else if (in_acc) begin
      ring_q[ptr_q] <= err_d;
      ptr_q         <= ptr_q + PtrW'(1);
      sum_q         <= sum_d;
      last_err_q    <= err_d;
    end
  end

  // Stage valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_a_q <= 1'b0;
      v_b_q <= 1'b0;
      v_c_q <= 1'b0;
    end else begin
      if (rdy_a) v_a_q <= s_axis_tvalid;
      if (rdy_b) v_b_q <= v_a_q;
      if (rdy_c) v_c_q <= v_b_q;
    end
  end

  // Stage A: hold the terms
  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      err_a_q <= err_d;
      avg_a_q <= avg_d;
      der_a_q <= der_d;
    end
  end

  // Stage B: three independent products
  assign prod_p_d = gain_prop_q * err_a_q;
  assign prod_i_d = gain_integ_q * avg_a_q;
  assign prod_d_d = gain_deriv_q * der_a_q;

  always_ff @(posedge clk_i) begin
    if (rdy_b) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
      err_b_q  <= err_a_q;
    end
  end

  // Stage C: sum, drop fraction bits (floor), saturate to the drive width
  always_comb begin
    acc    = AccW'(prod_p_q) + AccW'(prod_i_q) + AccW'(prod_d_q);
    acc_sh = acc >>> FracW;
    if (acc_sh[AccW-1:DriveW-1] == '0 || acc_sh[AccW-1:DriveW-1] == '1) begin
      drive_d = acc_sh[DriveW-1:0];
    end else if (acc_sh[AccW-1]) begin
      drive_d = {1'b1, {(DriveW-1){1'b0}}};
    end else begin
      drive_d = {1'b0, {(DriveW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_c) begin
      drive_c_q <= drive_d;
      err_c_q   <= err_b_q;
    end
  end

  assign m_axis_tvalid = v_c_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, err_c_q, drive_c_q};

  // The ring pointer steps by one on each accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ptr_q == $past(ptr_q) + PtrW'(1))
    else $error("ring pointer did not advance on accept");

  // Controller state holds when no request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(sum_q) && $stable(ptr_q) && $stable(last_err_q))
    else $error("controller state changed without a request");

  // An accepted request fills the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v_a_q)
    else $error("accepted request lost in first stage");

  // A full pipeline with a stalled output takes no new request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_a_q && v_b_q && v_c_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("request accepted into a full pipeline");

endmodule
